>>> rtl/core/abe_pkg.sv
// Package for the allocation bitmap engine.
// Sizes, state encoding and the control group of the byte unit.
// No dependencies.
package abe_pkg;

  // Bitmap size in entries (a multiple of 8, at most 4096 with 12 bit indexes)
  localparam int MAP_BITS    = 4096;
  localparam int IDX_W       = 12;
  localparam int CNT_W       = IDX_W + 1;
  localparam int STORE_BYTES = (MAP_BITS + 7) / 8;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int RESET_USED  = 4096;

  // Request modes
  localparam logic [1:0] MODE_SET  = 2'd0;
  localparam logic [1:0] MODE_CLR  = 2'd1;
  localparam logic [1:0] MODE_FIND = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN_RD,
    ST_RUN_WR,
    ST_FIND_RD,
    ST_FIND_CHK,
    ST_DONE
  } state_t;

  // Byte unit control: bit window [lo, hi] (MSB-first positions) and direction
  typedef struct packed {
    logic       set_used;
    logic [2:0] lo;
    logic [2:0] hi;
  } byte_ctl_t;

endpackage

>>> rtl/core/allocation_bitmap_engine.sv
// Top level of the allocation bitmap engine: sequencer, byte store, free count.
// Depends on abe_pkg and abe_byte_unit.
//
//   channel | signals                                     | dir | transfer when
//   in      | in_valid, mode, start_index, bit_count      | in  | in_valid & !in_stall
//   out     | out_valid, found_index, found, free_count   | out | out_valid & !out_stall
//   cfg     | cfg_wr_en, cfg_wr_data (used_bits)          | in  | cfg_wr_en
//
// Run request: each bitmap byte spanned is read, then written back; zero
// length or out-of-range runs go straight to done. Find: each byte is read
// and checked until a free bit or the last byte. The single-port byte store
// sets the rate. After reset a clearing pass writes all 512 bytes; in_stall is
// high meanwhile. A new request is taken while a result still waits in the
// output register; a finished request holds until that register frees.
module allocation_bitmap_engine (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                mode,
  input  logic [abe_pkg::IDX_W-1:0] start_index,
  input  logic [abe_pkg::CNT_W-1:0] bit_count,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [abe_pkg::IDX_W-1:0] found_index,
  output logic                      found,
  output logic [abe_pkg::CNT_W-1:0] free_count,
  input  logic                      cfg_wr_en,
  input  logic [abe_pkg::CNT_W-1:0] cfg_wr_data
);

  localparam int IDX_W  = abe_pkg::IDX_W;
  localparam int CNT_W  = abe_pkg::CNT_W;
  localparam int ADDR_W = abe_pkg::ADDR_W;
  localparam logic [CNT_W-1:0] MapSize = CNT_W'(abe_pkg::MAP_BITS);
  localparam logic [ADDR_W-1:0] LastAddr = ADDR_W'(abe_pkg::STORE_BYTES - 1);

  abe_pkg::state_t state, state_next;

  logic [ADDR_W-1:0] mem_addr, mem_addr_next;
  logic [ADDR_W-1:0] first_byte, first_byte_next;
  logic [ADDR_W-1:0] last_byte, last_byte_next;
  logic [2:0]        run_lo, run_lo_next;
  logic [2:0]        run_hi, run_hi_next;
  logic              set_used, set_used_next;
  logic [CNT_W-1:0]  used_bits, used_bits_next;
  logic [CNT_W-1:0]  free_entries, free_entries_next;
  logic [IDX_W-1:0]  res_index, res_index_next;
  logic              res_found, res_found_next;
  logic              out_valid_next;
  logic [IDX_W-1:0]  found_index_next;
  logic              found_next;
  logic [CNT_W-1:0]  free_count_next;

  logic [7:0]        store [abe_pkg::STORE_BYTES];
  logic [7:0]        rd_data;
  logic              mem_we;
  logic [7:0]        mem_wdata;

  abe_pkg::byte_ctl_t byte_ctl;
  logic [7:0]        unit_wdata;
  logic              unit_hit;
  logic [2:0]        unit_pos;

  // Request decode
  logic [CNT_W-1:0]  eff_size;
  logic [CNT_W-1:0]  start_ext;
  logic [CNT_W-1:0]  room;
  logic [CNT_W-1:0]  run_len;
  logic [CNT_W-1:0]  run_last;
  logic [CNT_W-1:0]  size_last;
  logic [CNT_W:0]    free_sum;
  logic              accept_in;
  logic              out_free;

  assign eff_size  = (used_bits > MapSize) ? MapSize : used_bits;
  assign start_ext = {1'b0, start_index};
  assign room      = eff_size - start_ext;
  assign run_len   = (start_ext < eff_size) ? ((bit_count < room) ? bit_count : room)
                                            : '0;
  assign run_last  = start_ext + run_len - CNT_W'(1);
  assign size_last = eff_size - CNT_W'(1);
  assign free_sum  = {1'b0, free_entries} + {1'b0, run_len};

  assign in_stall  = (state != abe_pkg::ST_IDLE);
  assign accept_in = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Byte unit window for the current address
  always_comb begin
    byte_ctl.set_used = set_used;
    byte_ctl.lo       = (mem_addr == first_byte) ? run_lo : 3'd0;
    byte_ctl.hi       = (mem_addr == last_byte) ? run_hi : 3'd7;
  end

  abe_byte_unit u_byte (
    .ctl     (byte_ctl),
    .rd_data (rd_data),
    .wr_data (unit_wdata),
    .hit     (unit_hit),
    .hit_pos (unit_pos)
  );

  // Byte store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_addr] <= mem_wdata;
    end
    rd_data <= store[mem_addr];
  end

  // Sequencer
  always_comb begin
    state_next        = state;
    mem_addr_next     = mem_addr;
    first_byte_next   = first_byte;
    last_byte_next    = last_byte;
    run_lo_next       = run_lo;
    run_hi_next       = run_hi;
    set_used_next     = set_used;
    used_bits_next    = used_bits;
    free_entries_next = free_entries;
    res_index_next    = res_index;
    res_found_next    = res_found;
    out_valid_next    = out_valid && out_stall;
    found_index_next  = found_index;
    found_next        = found;
    free_count_next   = free_count;
    mem_we            = 1'b0;
    mem_wdata         = unit_wdata;

    unique case (state)
      abe_pkg::ST_CLEAR: begin
        mem_we        = 1'b1;
        mem_wdata     = 8'h00;
        mem_addr_next = mem_addr + ADDR_W'(1);
        if (mem_addr == LastAddr) begin
          mem_addr_next = '0;
          state_next    = abe_pkg::ST_IDLE;
        end
      end

      abe_pkg::ST_IDLE: begin
        if (accept_in) begin
          res_index_next = '0;
          res_found_next = 1'b0;
          state_next     = abe_pkg::ST_DONE;
          if (mode == abe_pkg::MODE_SET || mode == abe_pkg::MODE_CLR) begin
            set_used_next   = (mode == abe_pkg::MODE_SET);
            mem_addr_next   = start_index[IDX_W-1:3];
            first_byte_next = start_index[IDX_W-1:3];
            last_byte_next  = run_last[IDX_W-1:3];
            run_lo_next     = start_index[2:0];
            run_hi_next     = run_last[2:0];
            if (mode == abe_pkg::MODE_SET) begin
              free_entries_next = (run_len > free_entries) ? '0 : free_entries - run_len;
            end else begin
              free_entries_next = (free_sum > {1'b0, eff_size}) ? eff_size
                                                                : free_sum[CNT_W-1:0];
            end
            if (run_len != '0) begin
              state_next = abe_pkg::ST_RUN_RD;
            end
          end else if (mode == abe_pkg::MODE_FIND) begin
            set_used_next   = 1'b0;
            mem_addr_next   = '0;
            first_byte_next = '0;
            last_byte_next  = size_last[IDX_W-1:3];
            run_lo_next     = 3'd0;
            run_hi_next     = size_last[2:0];
            if (eff_size != '0) begin
              state_next = abe_pkg::ST_FIND_RD;
            end
          end
        end
      end

      abe_pkg::ST_RUN_RD: begin
        state_next = abe_pkg::ST_RUN_WR;
      end

      abe_pkg::ST_RUN_WR: begin
        mem_we = 1'b1;
        if (mem_addr == last_byte) begin
          state_next = abe_pkg::ST_DONE;
        end else begin
          mem_addr_next = mem_addr + ADDR_W'(1);
          state_next    = abe_pkg::ST_RUN_RD;
        end
      end

      abe_pkg::ST_FIND_RD: begin
        state_next = abe_pkg::ST_FIND_CHK;
      end

      abe_pkg::ST_FIND_CHK: begin
        if (unit_hit) begin
          res_found_next = 1'b1;
          res_index_next = {mem_addr, unit_pos};
          state_next     = abe_pkg::ST_DONE;
        end else if (mem_addr == last_byte) begin
          state_next = abe_pkg::ST_DONE;
        end else begin
          mem_addr_next = mem_addr + ADDR_W'(1);
          state_next    = abe_pkg::ST_FIND_RD;
        end
      end

      abe_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_next   = 1'b1;
          found_index_next = res_index;
          found_next       = res_found;
          free_count_next  = free_entries;
          state_next       = abe_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = abe_pkg::ST_IDLE;
      end
    endcase

    // Register write reloads the free count
    if (cfg_wr_en) begin
      used_bits_next    = cfg_wr_data;
      free_entries_next = (cfg_wr_data > MapSize) ? MapSize : cfg_wr_data;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= abe_pkg::ST_CLEAR;
      mem_addr     <= '0;
      used_bits    <= CNT_W'(abe_pkg::RESET_USED);
      free_entries <= (CNT_W'(abe_pkg::RESET_USED) > MapSize) ? MapSize
                                                              : CNT_W'(abe_pkg::RESET_USED);
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      mem_addr     <= mem_addr_next;
      used_bits    <= used_bits_next;
      free_entries <= free_entries_next;
      out_valid    <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    first_byte  <= first_byte_next;
    last_byte   <= last_byte_next;
    run_lo      <= run_lo_next;
    run_hi      <= run_hi_next;
    set_used    <= set_used_next;
    res_index   <= res_index_next;
    res_found   <= res_found_next;
    found_index <= found_index_next;
    found       <= found_next;
    free_count  <= free_count_next;
  end

  // Free count never exceeds the effective size
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_entries <= eff_size)
    else $error("free count above effective size");

  // A not-found result carries index zero
  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (found_index == '0))
    else $error("nonzero index on not-found result");

  // Run writes stay inside the span of the run
  a_run_span: assert property (@(posedge clk) disable iff (rst)
    (state == abe_pkg::ST_RUN_WR) |-> (mem_addr >= first_byte && mem_addr <= last_byte))
    else $error("run write outside its span");

  // A new result only comes out of the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid_next && !(out_valid && out_stall)) |-> (state == abe_pkg::ST_DONE))
    else $error("result loaded outside done state");

endmodule

>>> rtl/core/abe_byte_unit.sv
// Shared byte unit of the allocation bitmap engine: builds the window mask,
// applies a set or clear, and finds the first free bit inside the window.
// Depends on abe_pkg.
module abe_byte_unit (
  input  abe_pkg::byte_ctl_t ctl,
  input  logic [7:0]         rd_data,
  output logic [7:0]         wr_data,
  output logic               hit,
  output logic [2:0]         hit_pos
);

  logic [7:0] mask;
  logic [7:0] avail;

  // Window mask; entry j of the byte sits at bit 7-j
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      mask[7-j] = (3'(j) >= ctl.lo) && (3'(j) <= ctl.hi);
    end
  end

  // Modify for run requests
  assign wr_data = ctl.set_used ? (rd_data | mask) : (rd_data & ~mask);

  // Lowest free entry in the window
  assign avail = ~rd_data & mask;

  always_comb begin
    hit     = 1'b0;
    hit_pos = 3'd0;
    for (int j = 7; j >= 0; j--) begin
      if (avail[7-j]) begin
        hit     = 1'b1;
        hit_pos = 3'(j);
      end
    end
  end

endmodule
